// File: hdl/cpp_command_packet_sequencer_top_assert.svh
// Assertion macros shared by the command packet sequencer modules
`ifndef CPP_COMMAND_PACKET_SEQUENCER_TOP_ASSERT_SVH
`define CPP_COMMAND_PACKET_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every edge outside reset
`define CPP_CS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// Condition in one cycle implies a consequence in the next
`define CPP_CS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPP_CS_ASSERT(label, prop, msg)
`define CPP_CS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hdl/cpp_cs_pkg.sv
// Types, codes and the job expansion function of the command packet sequencer
`timescale 1ns / 1ps

package cpp_cs_pkg;

  // Input command codes
  localparam logic [1:0] CMD_DAISY  = 2'd0;
  localparam logic [1:0] CMD_MUX    = 2'd1;
  localparam logic [1:0] CMD_ASSIGN = 2'd2;
  localparam logic [1:0] CMD_STATUS = 2'd3;

  // Pin action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_STROBE = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;
  localparam logic [1:0] ACT_DONE   = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_CHECK1 = 3'd1;
  localparam logic [2:0] ERR_CHECK2 = 3'd2;
  localparam logic [2:0] ERR_NO_ACK = 3'd3;
  localparam logic [2:0] ERR_UNEXP  = 3'd4;

  // Status register bits
  localparam int ST_ERROR_BIT    = 3;
  localparam int ST_SELECT_BIT   = 4;
  localparam int ST_PAPEROUT_BIT = 5;
  localparam int ST_ACK_BIT      = 6;
  localparam int ST_BUSY_BIT     = 7;
  localparam logic [7:0] ST_MASK   = 8'hB8;
  localparam logic [7:0] CHK1_WANT = 8'hB8;
  localparam logic [7:0] CHK2_WANT = 8'h18;

  // Result step counter width: at most eight results per item
  localparam int STEP_W = 3;

  // Work handed from the front to the back
  typedef enum logic [2:0] {
    JOB_DONE     = 3'd0,  // done with value and error
    JOB_FF_DONE  = 3'd1,  // write FF, done with value
    JOB_MUX      = 3'd2,  // mux packet and status request
    JOB_CHK1     = 3'd3,  // daisy preamble and status request
    JOB_CHK2     = 3'd4,  // write 87, status request
    JOB_CMD      = 3'd5,  // write 78, byte, strobe, status request
    JOB_NEXT     = 3'd6,  // write address, strobe, status request
    JOB_NEXT_END = 3'd7   // write address, strobe, FF, done with count
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] arg;
    logic [7:0] value;
    logic [2:0] err;
  } job_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [7:0] result_value;
    logic [2:0] error_code;
    logic       last;
  } res_t;

  function automatic res_t mk_write(input logic [7:0] b, input logic lst);
    res_t r;
    r = '0;
    r.action    = ACT_WRITE;
    r.data_byte = b;
    r.last      = lst;
    return r;
  endfunction

  function automatic res_t mk_act(input logic [1:0] a, input logic lst);
    res_t r;
    r = '0;
    r.action = a;
    r.last   = lst;
    return r;
  endfunction

  function automatic res_t mk_done(input logic [7:0] v, input logic [2:0] e);
    res_t r;
    r = '0;
    r.action       = ACT_DONE;
    r.result_value = v;
    r.error_code   = e;
    r.last         = 1'b1;
    return r;
  endfunction

  // Result produced by a job at a given step; last marks its final one
  function automatic res_t expand(input job_t j, input logic [STEP_W-1:0] step);
    res_t r;
    r = mk_done(8'h00, ERR_OK);
    unique case (j.kind)
      JOB_DONE: r = mk_done(j.value, j.err);
      JOB_FF_DONE: begin
        if (step == STEP_W'(0)) r = mk_write(8'hFF, 1'b0);
        else                    r = mk_done(j.value, ERR_OK);
      end
      JOB_MUX: begin
        unique case (step)
          STEP_W'(0): r = mk_write(8'hAA, 1'b0);
          STEP_W'(1): r = mk_write(8'h55, 1'b0);
          STEP_W'(2): r = mk_write(8'hF0, 1'b0);
          STEP_W'(3): r = mk_write(8'h0F, 1'b0);
          STEP_W'(4): r = mk_write(8'h52, 1'b0);
          STEP_W'(5): r = mk_write(8'hAD, 1'b0);
          STEP_W'(6): r = mk_write(j.arg, 1'b0);
          default:    r = mk_act(ACT_STATUS, 1'b1);
        endcase
      end
      JOB_CHK1: begin
        unique case (step)
          STEP_W'(0): r = mk_write(8'hAA, 1'b0);
          STEP_W'(1): r = mk_write(8'h55, 1'b0);
          STEP_W'(2): r = mk_write(8'h00, 1'b0);
          STEP_W'(3): r = mk_write(8'hFF, 1'b0);
          default:    r = mk_act(ACT_STATUS, 1'b1);
        endcase
      end
      JOB_CHK2: begin
        if (step == STEP_W'(0)) r = mk_write(8'h87, 1'b0);
        else                    r = mk_act(ACT_STATUS, 1'b1);
      end
      JOB_CMD: begin
        unique case (step)
          STEP_W'(0): r = mk_write(8'h78, 1'b0);
          STEP_W'(1): r = mk_write(j.arg, 1'b0);
          STEP_W'(2): r = mk_act(ACT_STROBE, 1'b0);
          default:    r = mk_act(ACT_STATUS, 1'b1);
        endcase
      end
      JOB_NEXT: begin
        unique case (step)
          STEP_W'(0): r = mk_write(j.arg, 1'b0);
          STEP_W'(1): r = mk_act(ACT_STROBE, 1'b0);
          default:    r = mk_act(ACT_STATUS, 1'b1);
        endcase
      end
      JOB_NEXT_END: begin
        unique case (step)
          STEP_W'(0): r = mk_write(j.arg, 1'b0);
          STEP_W'(1): r = mk_act(ACT_STROBE, 1'b0);
          STEP_W'(2): r = mk_write(8'hFF, 1'b0);
          default:    r = mk_done(j.value, ERR_OK);
        endcase
      end
      default: r = mk_done(8'h00, ERR_OK);
    endcase
    return r;
  endfunction

endpackage

// File: hdl/cpp_cs_front.sv
// Front end: protocol state, item classification and the job queue
`timescale 1ns / 1ps
`include "cpp_command_packet_sequencer_top_assert.svh"

module cpp_cs_front #(
  parameter int MAX_CHAIN_DEVICES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_cmd_byte,
  input  logic [7:0]        in_status_byte,
  output logic              job_valid,
  output cpp_cs_pkg::job_t  job,
  input  logic              job_pop
);

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_CHECK1    = 6'b000010,
    PH_CHECK2    = 6'b000100,
    PH_DAISY_END = 6'b001000,
    PH_MUX_END   = 6'b010000,
    PH_CHAIN     = 6'b100000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [1:0]         operation_r, operation_nxt;
  logic [7:0]         held_r, held_nxt;
  logic [2:0]         chain_index_r, chain_index_nxt;
  logic [2:0]         idx_inc;
  cpp_cs_pkg::job_t   new_job;
  logic               accept;

  // Job queue, two entries
  cpp_cs_pkg::job_t   jq_r [2];
  logic               jq_wptr_r, jq_rptr_r;
  logic [1:0]         jq_cnt_r;

  assign in_full   = (jq_cnt_r == 2'd2);
  assign accept    = in_push && !in_full;
  assign job_valid = (jq_cnt_r != 2'd0);
  assign job       = jq_r[jq_rptr_r];
  assign idx_inc   = chain_index_r + 3'd1;

  // Classify the item against the current phase
  always_comb begin
    phase_nxt       = phase_r;
    operation_nxt   = operation_r;
    held_nxt        = held_r;
    chain_index_nxt = chain_index_r;
    new_job         = '0;
    new_job.kind    = cpp_cs_pkg::JOB_DONE;
    new_job.err     = cpp_cs_pkg::ERR_UNEXP;
    if (phase_r == PH_IDLE) begin
      if (in_command == cpp_cs_pkg::CMD_STATUS) begin
        new_job.err = cpp_cs_pkg::ERR_UNEXP;
      end else if (in_command == cpp_cs_pkg::CMD_MUX) begin
        new_job.kind  = cpp_cs_pkg::JOB_MUX;
        new_job.arg   = in_cmd_byte;
        new_job.err   = cpp_cs_pkg::ERR_OK;
        operation_nxt = in_command;
        held_nxt      = in_cmd_byte;
        phase_nxt     = PH_MUX_END;
      end else begin
        new_job.kind    = cpp_cs_pkg::JOB_CHK1;
        new_job.err     = cpp_cs_pkg::ERR_OK;
        operation_nxt   = in_command;
        held_nxt        = in_cmd_byte;
        chain_index_nxt = 3'd0;
        phase_nxt       = PH_CHECK1;
      end
    end else if (in_command != cpp_cs_pkg::CMD_STATUS) begin
      new_job.err = cpp_cs_pkg::ERR_UNEXP;
    end else begin
      new_job.err = cpp_cs_pkg::ERR_OK;
      unique case (phase_r)
        PH_CHECK1: begin
          if ((in_status_byte & cpp_cs_pkg::ST_MASK) != cpp_cs_pkg::CHK1_WANT) begin
            new_job.err = cpp_cs_pkg::ERR_CHECK1;
            phase_nxt   = PH_IDLE;
          end else begin
            new_job.kind = cpp_cs_pkg::JOB_CHK2;
            phase_nxt    = PH_CHECK2;
          end
        end
        PH_CHECK2: begin
          if ((in_status_byte & cpp_cs_pkg::ST_MASK) != cpp_cs_pkg::CHK2_WANT) begin
            new_job.err = cpp_cs_pkg::ERR_CHECK2;
            phase_nxt   = PH_IDLE;
          end else if (operation_r == cpp_cs_pkg::CMD_ASSIGN) begin
            new_job.kind    = cpp_cs_pkg::JOB_CMD;
            new_job.arg     = 8'h00;
            chain_index_nxt = 3'd0;
            phase_nxt       = PH_CHAIN;
          end else begin
            new_job.kind = cpp_cs_pkg::JOB_CMD;
            new_job.arg  = held_r;
            phase_nxt    = PH_DAISY_END;
          end
        end
        PH_DAISY_END: begin
          new_job.kind  = cpp_cs_pkg::JOB_FF_DONE;
          new_job.value = in_status_byte;
          phase_nxt     = PH_IDLE;
        end
        PH_MUX_END: begin
          if (!in_status_byte[cpp_cs_pkg::ST_ACK_BIT]) begin
            new_job.err = cpp_cs_pkg::ERR_NO_ACK;
          end else begin
            new_job.value = {4'b0000,
                             ~in_status_byte[cpp_cs_pkg::ST_ERROR_BIT],
                             ~in_status_byte[cpp_cs_pkg::ST_BUSY_BIT],
                             in_status_byte[cpp_cs_pkg::ST_PAPEROUT_BIT],
                             in_status_byte[cpp_cs_pkg::ST_SELECT_BIT]};
          end
          phase_nxt = PH_IDLE;
        end
        PH_CHAIN: begin
          chain_index_nxt = idx_inc;
          new_job.arg     = {5'b00000, idx_inc};
          new_job.value   = {5'b00000, idx_inc};
          if (idx_inc >= 3'(MAX_CHAIN_DEVICES)) begin
            new_job.kind = cpp_cs_pkg::JOB_FF_DONE;
            phase_nxt    = PH_IDLE;
          end else if (!in_status_byte[cpp_cs_pkg::ST_BUSY_BIT]) begin
            new_job.kind = cpp_cs_pkg::JOB_NEXT_END;
            phase_nxt    = PH_IDLE;
          end else begin
            new_job.kind = cpp_cs_pkg::JOB_NEXT;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Protocol state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      operation_r   <= 2'd0;
      held_r        <= 8'h00;
      chain_index_r <= 3'd0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      operation_r   <= operation_nxt;
      held_r        <= held_nxt;
      chain_index_r <= chain_index_nxt;
    end
  end

  // Job queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jq_wptr_r <= 1'b0;
      jq_rptr_r <= 1'b0;
      jq_cnt_r  <= 2'd0;
    end else begin
      if (accept)  jq_wptr_r <= ~jq_wptr_r;
      if (job_pop) jq_rptr_r <= ~jq_rptr_r;
      jq_cnt_r <= jq_cnt_r + {1'b0, accept} - {1'b0, job_pop};
    end
  end

  // Job queue storage
  always_ff @(posedge clk) begin
    if (accept) jq_r[jq_wptr_r] <= new_job;
  end

  `CPP_CS_ASSERT(a_jq_bound, jq_cnt_r <= 2'd2, "job queue over capacity")
  `CPP_CS_ASSERT(a_chain_bound,
    (phase_r != PH_CHAIN) || (chain_index_r < 3'(MAX_CHAIN_DEVICES)),
    "chain index beyond device limit")
  `CPP_CS_ASSERT_NEXT(a_unexp_keeps_phase,
    accept && (phase_r != PH_IDLE) && (in_command != cpp_cs_pkg::CMD_STATUS),
    $stable(phase_r), "unexpected start item disturbed the sequence")

endmodule

// File: hdl/cpp_cs_back.sv
// Back end: expands jobs into pin actions and holds the result queue
`timescale 1ns / 1ps
`include "cpp_command_packet_sequencer_top_assert.svh"

module cpp_cs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  cpp_cs_pkg::job_t  job,
  output logic              job_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output cpp_cs_pkg::res_t  out_res
);

  cpp_cs_pkg::job_t                cur_r;
  logic                            cur_valid_r;
  logic [cpp_cs_pkg::STEP_W-1:0]   step_r;
  cpp_cs_pkg::res_t                res;
  logic                            emit, take, deq;

  // Result queue, two entries
  cpp_cs_pkg::res_t  oq_r [2];
  logic              oq_wptr_r, oq_rptr_r;
  logic [1:0]        oq_cnt_r;

  assign res       = cpp_cs_pkg::expand(cur_r, step_r);
  assign emit      = cur_valid_r && (oq_cnt_r != 2'd2);
  assign take      = !cur_valid_r || (emit && res.last);
  assign job_pop   = take && job_valid;
  assign out_empty = (oq_cnt_r == 2'd0);
  assign deq       = out_pop && !out_empty;
  assign out_res   = oq_r[oq_rptr_r];

  // Expander control: step through the current job, load the next at its end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (take) begin
      cur_valid_r <= job_valid;
      step_r      <= '0;
    end else if (emit) begin
      step_r <= step_r + 1'b1;
    end
  end

  // Current job payload
  always_ff @(posedge clk) begin
    if (job_pop) cur_r <= job;
  end

  // Result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r <= 1'b0;
      oq_rptr_r <= 1'b0;
      oq_cnt_r  <= 2'd0;
    end else begin
      if (emit) oq_wptr_r <= ~oq_wptr_r;
      if (deq)  oq_rptr_r <= ~oq_rptr_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, emit} - {1'b0, deq};
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (emit) oq_r[oq_wptr_r] <= res;
  end

  `CPP_CS_ASSERT(a_oq_bound, oq_cnt_r <= 2'd2, "result queue over capacity")
  `CPP_CS_ASSERT(a_pop_valid, !job_pop || job_valid, "job taken from empty queue")
  `CPP_CS_ASSERT_NEXT(a_step_adv, emit && !res.last,
    cur_valid_r && (step_r == $past(step_r) + 1'b1), "expander step did not advance")

endmodule

// File: hdl/cpp_command_packet_sequencer_top.sv
// Top level of the IEEE 1284.3 command packet sequencer
// The first result of an item passes through the job queue and the current job register.
// Throughput: the expander emits one result a cycle while the result queue has room; an
// item causes 1 to 8 results, and items enter back to back while the two-entry job
// queue has room.
// Reset: synchronous, active low; clears the protocol state and both queues.
`timescale 1ns / 1ps

module cpp_command_packet_sequencer_top #(
  parameter int MAX_CHAIN_DEVICES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_command,
  input  logic [7:0] in_cmd_byte,
  input  logic [7:0] in_status_byte,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [1:0] out_action,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_result_value,
  output logic [2:0] out_error_code,
  output logic       out_last
);

  logic              job_valid;
  logic              job_pop;
  cpp_cs_pkg::job_t  job;
  cpp_cs_pkg::res_t  out_res;

  // Front end: classification and protocol state
  cpp_cs_front #(
    .MAX_CHAIN_DEVICES(MAX_CHAIN_DEVICES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_cmd_byte    (in_cmd_byte),
    .in_status_byte (in_status_byte),
    .job_valid      (job_valid),
    .job            (job),
    .job_pop        (job_pop)
  );

  // Back end: pin action expansion
  cpp_cs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (out_res)
  );

  assign out_action       = out_res.action;
  assign out_data_byte    = out_res.data_byte;
  assign out_result_value = out_res.result_value;
  assign out_error_code   = out_res.error_code;
  assign out_last         = out_res.last;

endmodule

// File: tb/cpp_command_packet_sequencer_check.sv
// Checker for the command packet sequencer: predicts pin actions and compares them
`timescale 1ns / 1ps

module cpp_command_packet_sequencer_check #(
  parameter int MAX_CHAIN_DEVICES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [1:0] in_command,
  input  logic [7:0] in_cmd_byte,
  input  logic [7:0] in_status_byte,
  input  logic       out_pop,
  input  logic       out_empty,
  input  logic [1:0] out_action,
  input  logic [7:0] out_data_byte,
  input  logic [7:0] out_result_value,
  input  logic [2:0] out_error_code,
  input  logic       out_last,
  output int         mismatch_count,
  output int         results_pending
);

  import cpp_cs_pkg::*;

  // Protocol phase of the sequencer as seen from the host side
  typedef enum logic [2:0] {
    SEQ_IDLE      = 3'd0,
    SEQ_CHECK1    = 3'd1,
    SEQ_CHECK2    = 3'd2,
    SEQ_DAISY_END = 3'd3,
    SEQ_MUX_END   = 3'd4,
    SEQ_CHAIN     = 3'd5
  } seq_phase_t;

  seq_phase_t seq_phase;
  logic [1:0] seq_op;
  logic [7:0] held_cmd;
  logic [2:0] chain_idx;
  logic [2:0] found_cnt;

  res_t expected_actions[$];

  // Append one pin action to the expected list, last cleared
  task automatic add_action(input logic [1:0] act, input logic [7:0] data,
                            input logic [7:0] val, input logic [2:0] err);
    res_t r;
    r              = '0;
    r.action       = act;
    r.data_byte    = data;
    r.result_value = val;
    r.error_code   = err;
    expected_actions.push_back(r);
  endtask

  // Work out the pin actions caused by one accepted item
  task automatic predict_pin_actions(input logic [1:0] cmd, input logic [7:0] cb,
                                     input logic [7:0] st);
    int   first_new;
    logic end_mark;
    first_new = expected_actions.size();
    if (seq_phase == SEQ_IDLE) begin
      if (cmd == CMD_STATUS) begin
        // reply with nothing outstanding
        add_action(ACT_DONE, 8'h00, 8'h00, ERR_UNEXP);
      end else if (cmd == CMD_MUX) begin
        add_action(ACT_WRITE, 8'hAA, 8'h00, ERR_OK);
        add_action(ACT_WRITE, 8'h55, 8'h00, ERR_OK);
        add_action(ACT_WRITE, 8'hF0, 8'h00, ERR_OK);
        add_action(ACT_WRITE, 8'h0F, 8'h00, ERR_OK);
        add_action(ACT_WRITE, 8'h52, 8'h00, ERR_OK);
        add_action(ACT_WRITE, 8'hAD, 8'h00, ERR_OK);
        add_action(ACT_WRITE, cb, 8'h00, ERR_OK);
        add_action(ACT_STATUS, 8'h00, 8'h00, ERR_OK);
        seq_op    = CMD_MUX;
        held_cmd  = cb;
        seq_phase = SEQ_MUX_END;
      end else begin
        // daisy command and address assignment share the preamble
        add_action(ACT_WRITE, 8'hAA, 8'h00, ERR_OK);
        add_action(ACT_WRITE, 8'h55, 8'h00, ERR_OK);
        add_action(ACT_WRITE, 8'h00, 8'h00, ERR_OK);
        add_action(ACT_WRITE, 8'hFF, 8'h00, ERR_OK);
        add_action(ACT_STATUS, 8'h00, 8'h00, ERR_OK);
        seq_op    = cmd;
        held_cmd  = cb;
        chain_idx = '0;
        found_cnt = '0;
        seq_phase = SEQ_CHECK1;
      end
    end else if (cmd != CMD_STATUS) begin
      // start while a reply is awaited: rejected, sequence keeps waiting
      add_action(ACT_DONE, 8'h00, 8'h00, ERR_UNEXP);
    end else begin
      case (seq_phase)
        SEQ_CHECK1: begin
          if ((st & ST_MASK) != CHK1_WANT) begin
            add_action(ACT_DONE, 8'h00, 8'h00, ERR_CHECK1);
            seq_phase = SEQ_IDLE;
          end else begin
            add_action(ACT_WRITE, 8'h87, 8'h00, ERR_OK);
            add_action(ACT_STATUS, 8'h00, 8'h00, ERR_OK);
            seq_phase = SEQ_CHECK2;
          end
        end
        SEQ_CHECK2: begin
          if ((st & ST_MASK) != CHK2_WANT) begin
            add_action(ACT_DONE, 8'h00, 8'h00, ERR_CHECK2);
            seq_phase = SEQ_IDLE;
          end else begin
            add_action(ACT_WRITE, 8'h78, 8'h00, ERR_OK);
            add_action(ACT_WRITE, (seq_op == CMD_ASSIGN) ? 8'h00 : held_cmd,
                       8'h00, ERR_OK);
            add_action(ACT_STROBE, 8'h00, 8'h00, ERR_OK);
            add_action(ACT_STATUS, 8'h00, 8'h00, ERR_OK);
            if (seq_op == CMD_ASSIGN) begin
              chain_idx = '0;
              found_cnt = '0;
              seq_phase = SEQ_CHAIN;
            end else begin
              seq_phase = SEQ_DAISY_END;
            end
          end
        end
        SEQ_DAISY_END: begin
          add_action(ACT_WRITE, 8'hFF, 8'h00, ERR_OK);
          add_action(ACT_DONE, 8'h00, st, ERR_OK);
          seq_phase = SEQ_IDLE;
        end
        SEQ_MUX_END: begin
          if (!st[ST_ACK_BIT]) begin
            add_action(ACT_DONE, 8'h00, 8'h00, ERR_NO_ACK);
          end else begin
            add_action(ACT_DONE, 8'h00,
                       {4'b0000, ~st[ST_ERROR_BIT], ~st[ST_BUSY_BIT],
                        st[ST_PAPEROUT_BIT], st[ST_SELECT_BIT]}, ERR_OK);
          end
          seq_phase = SEQ_IDLE;
        end
        default: begin
          // chain walk: busy clear marks the last device
          end_mark  = ~st[ST_BUSY_BIT];
          found_cnt = found_cnt + 3'd1;
          chain_idx = chain_idx + 3'd1;
          if (chain_idx >= MAX_CHAIN_DEVICES) begin
            add_action(ACT_WRITE, 8'hFF, 8'h00, ERR_OK);
            add_action(ACT_DONE, 8'h00, {5'b00000, found_cnt}, ERR_OK);
            seq_phase = SEQ_IDLE;
          end else begin
            add_action(ACT_WRITE, {5'b00000, chain_idx}, 8'h00, ERR_OK);
            add_action(ACT_STROBE, 8'h00, 8'h00, ERR_OK);
            if (end_mark) begin
              add_action(ACT_WRITE, 8'hFF, 8'h00, ERR_OK);
              add_action(ACT_DONE, 8'h00, {5'b00000, found_cnt}, ERR_OK);
              seq_phase = SEQ_IDLE;
            end else begin
              add_action(ACT_STATUS, 8'h00, 8'h00, ERR_OK);
            end
          end
        end
      endcase
    end
    if (expected_actions.size() > first_new)
      expected_actions[expected_actions.size() - 1].last = 1'b1;
  endtask

  // Count a failure; only the first ten are shown
  task automatic note_failure(input string what, input res_t want, input res_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t mismatch (%s): expected act=%0d data=%h val=%h err=%0d last=%b",
               $realtime, what, want.action, want.data_byte, want.result_value,
               want.error_code, want.last);
      $display("    got act=%0d data=%h val=%h err=%0d last=%b",
               got.action, got.data_byte, got.result_value, got.error_code,
               got.last);
    end
  endtask

  // Compare one popped result with the oldest expectation
  task automatic check_pin_action();
    res_t got;
    res_t want;
    got.action       = out_action;
    got.data_byte    = out_data_byte;
    got.result_value = out_result_value;
    got.error_code   = out_error_code;
    got.last         = out_last;
    if (expected_actions.size() == 0) begin
      note_failure("no item expected", '0, got);
    end else begin
      want = expected_actions.pop_front();
      if (got.action !== want.action || got.data_byte !== want.data_byte ||
          got.result_value !== want.result_value ||
          got.error_code !== want.error_code || got.last !== want.last)
        note_failure("field", want, got);
    end
  endtask

  // Watch both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      seq_phase      = SEQ_IDLE;
      seq_op         = '0;
      held_cmd       = '0;
      chain_idx      = '0;
      found_cnt      = '0;
      mismatch_count = 0;
      expected_actions.delete();
    end else begin
      if (in_push && !in_full)
        predict_pin_actions(in_command, in_cmd_byte, in_status_byte);
      if (out_pop && !out_empty)
        check_pin_action();
    end
    results_pending = expected_actions.size();
  end

endmodule

// File: tb/cpp_command_packet_sequencer_top_test.sv
// Stimulus and verdict for the command packet sequencer
`timescale 1ns / 1ps

module cpp_command_packet_sequencer_top_test;

  import cpp_cs_pkg::*;

  localparam int MAX_DEV = 4;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_push        = 1'b0;
  logic       in_full;
  logic [1:0] in_command     = CMD_STATUS;
  logic [7:0] in_cmd_byte    = 8'h00;
  logic [7:0] in_status_byte = 8'h00;
  logic       out_pop        = 1'b0;
  logic       out_empty;
  logic [1:0] out_action;
  logic [7:0] out_data_byte;
  logic [7:0] out_result_value;
  logic [2:0] out_error_code;
  logic       out_last;
  int         mismatch_count;
  int         results_pending;
  int         sent_items = 0;

  cpp_command_packet_sequencer_top #(.MAX_CHAIN_DEVICES(MAX_DEV)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_cmd_byte      (in_cmd_byte),
    .in_status_byte   (in_status_byte),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_action       (out_action),
    .out_data_byte    (out_data_byte),
    .out_result_value (out_result_value),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

  cpp_command_packet_sequencer_check #(.MAX_CHAIN_DEVICES(MAX_DEV)) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_cmd_byte      (in_cmd_byte),
    .in_status_byte   (in_status_byte),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_action       (out_action),
    .out_data_byte    (out_data_byte),
    .out_result_value (out_result_value),
    .out_error_code   (out_error_code),
    .out_last         (out_last),
    .mismatch_count   (mismatch_count),
    .results_pending  (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item and hold it until accepted, then maybe idle
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] cb,
                           input logic [7:0] st);
    in_push        <= 1'b1;
    in_command     <= cmd;
    in_cmd_byte    <= cb;
    in_status_byte <= st;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent_items++;
    // items 60..89 go back to back
    if (!(sent_items >= 60 && sent_items < 90) && $urandom_range(0, 99) < 33) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Now and then a start item arrives while a reply is awaited
  task automatic maybe_stray_start();
    if ($urandom_range(0, 7) == 0)
      send_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
  endtask

  // One of the status bits that the checks look at
  function automatic logic [7:0] pick_mask_bit();
    case ($urandom_range(0, 3))
      0:       return 8'h08;
      1:       return 8'h10;
      2:       return 8'h20;
      default: return 8'h80;
    endcase
  endfunction

  // A well-formed operation with random content, or a stray reply
  task automatic random_sequence();
    int         pick;
    logic [1:0] start_cmd;
    logic [7:0] st;
    bit         pass;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      send_item(CMD_STATUS, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      return;
    end
    if (pick <= 3) begin
      send_item(CMD_MUX, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      maybe_stray_start();
      st = 8'($urandom_range(0, 255));
      st[ST_ACK_BIT] = ($urandom_range(0, 3) != 0);
      send_item(CMD_STATUS, 8'($urandom_range(0, 255)), st);
      return;
    end
    start_cmd = (pick <= 6) ? CMD_DAISY : CMD_ASSIGN;
    send_item(start_cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    maybe_stray_start();
    // first check
    pass = ($urandom_range(0, 7) != 0);
    st   = 8'($urandom_range(0, 255));
    if (pass) st = st | CHK1_WANT;
    else if ((st & ST_MASK) == CHK1_WANT) st = st ^ pick_mask_bit();
    send_item(CMD_STATUS, 8'($urandom_range(0, 255)), st);
    if (!pass) return;
    maybe_stray_start();
    // second check
    pass = ($urandom_range(0, 7) != 0);
    st   = 8'($urandom_range(0, 255));
    if (pass) st = (st & ~ST_MASK) | CHK2_WANT;
    else if ((st & ST_MASK) == CHK2_WANT) st = st ^ pick_mask_bit();
    send_item(CMD_STATUS, 8'($urandom_range(0, 255)), st);
    if (!pass) return;
    if (start_cmd == CMD_DAISY) begin
      maybe_stray_start();
      send_item(CMD_STATUS, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      return;
    end
    // chain walk: busy clear ends it early
    for (int k = 1; k <= MAX_DEV; k++) begin
      maybe_stray_start();
      st = 8'($urandom_range(0, 255));
      st[ST_BUSY_BIT] = ($urandom_range(0, 2) != 0);
      send_item(CMD_STATUS, 8'($urandom_range(0, 255)), st);
      if (!st[ST_BUSY_BIT]) break;
    end
  endtask

  // Result side: random pops, one long hold-off, one steady stretch
  initial begin
    int cyc;
    cyc = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 150 && cyc < 230)
        out_pop <= 1'b0;
      else if (cyc >= 250 && cyc < 400)
        out_pop <= 1'b1;
      else
        out_pop <= ($urandom_range(0, 99) >= 33);
    end
  end

  // Reset, directed items, random sequences, drain, verdict
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reply while idle
    send_item(CMD_STATUS, 8'h00, 8'hFF);
    // daisy command with a stray start during the first wait
    send_item(CMD_DAISY, 8'h00, 8'h00);
    send_item(CMD_MUX, 8'hFF, 8'h00);
    send_item(CMD_STATUS, 8'hFF, 8'hFF);
    send_item(CMD_STATUS, 8'h00, 8'h5F);
    send_item(CMD_STATUS, 8'h00, 8'hFF);
    // mux with ack, mux without ack
    send_item(CMD_MUX, 8'hFF, 8'h00);
    send_item(CMD_STATUS, 8'h00, 8'hFF);
    send_item(CMD_MUX, 8'h30, 8'hFF);
    send_item(CMD_STATUS, 8'hFF, 8'hBF);
    // first check fails
    send_item(CMD_DAISY, 8'hE0, 8'h00);
    send_item(CMD_STATUS, 8'h00, 8'h00);
    // second check fails
    send_item(CMD_ASSIGN, 8'h00, 8'h00);
    send_item(CMD_STATUS, 8'h00, 8'hB8);
    send_item(CMD_STATUS, 8'h00, 8'hB8);
    // full chain of devices
    send_item(CMD_ASSIGN, 8'hFF, 8'hFF);
    send_item(CMD_STATUS, 8'h00, 8'hB8);
    send_item(CMD_STATUS, 8'h00, 8'h18);
    repeat (MAX_DEV) send_item(CMD_STATUS, 8'h00, 8'h80);
    // chain ends at the first device
    send_item(CMD_ASSIGN, 8'h00, 8'h00);
    send_item(CMD_STATUS, 8'h00, 8'hFF);
    send_item(CMD_STATUS, 8'hFF, 8'h18);
    send_item(CMD_STATUS, 8'h00, 8'h7F);

    while (sent_items < 100) random_sequence();
    in_push <= 1'b0;

    // let the checker record the last item before watching the drain
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("[cpp_command_packet_sequencer_top] OK");
    else
      $display("[cpp_command_packet_sequencer_top] ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[cpp_command_packet_sequencer_top] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/cpp_cs_pkg.sv
hdl/cpp_cs_front.sv
hdl/cpp_cs_back.sv
hdl/cpp_command_packet_sequencer_top.sv
tb/cpp_command_packet_sequencer_check.sv
tb/cpp_command_packet_sequencer_top_test.sv
